### hw/rtl/sphere_obb_intersect_macros.svh
// Assertion macros used by the sphere/box intersection RTL.
`ifndef SPHERE_OBB_INTERSECT_MACROS_SVH
`define SPHERE_OBB_INTERSECT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define SOI_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SOI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/soi_pkg.sv
// Package: widths, constants and word types for the sphere/box intersection block.
package soi_pkg;

    localparam int COMP_W    = 16;              // bits per packed component
    localparam int VEC_W     = 3 * COMP_W;      // packed x,y,z vector
    localparam int AXIS_FRAC = COMP_W - 2;      // fraction bits of an axis component

    localparam int D_W    = COMP_W + 1;         // centre offset, clamped projection
    localparam int P_W    = D_W + COMP_W;       // one product against an axis component
    localparam int ACC1_W = P_W + 2;            // projection sum
    localparam int RND1_W = ACC1_W - AXIS_FRAC; // projection after rounding
    localparam int ACC2_W = P_W + 3;            // rebuilt point sum
    localparam int CP_W   = ACC2_W - AXIS_FRAC; // rebuilt point after rounding
    localparam int V_W    = CP_W + 1;           // point minus sphere centre
    localparam int SQ_W   = 2 * V_W;            // one squared difference
    localparam int DD_W   = SQ_W + 2;           // squared distance
    localparam int RR_W   = 2 * COMP_W;         // radius squared

    localparam int N_STAGES = 9;

    // Half an output LSB at the projection's scale
    localparam logic signed [ACC1_W-1:0] RND_BIAS = ACC1_W'(1) << (AXIS_FRAC - 1);

    localparam logic signed [CP_W-1:0] SAT_MAX = CP_W'((2 ** (COMP_W - 1)) - 1);
    localparam logic signed [CP_W-1:0] SAT_MIN = CP_W'(-(2 ** (COMP_W - 1)));

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct packed {
        logic [VEC_W-1:0]  sphere_center;
        logic [COMP_W-1:0] sphere_radius;
        logic [VEC_W-1:0]  box_center;
        logic [VEC_W-1:0]  box_half_size;
        logic [VEC_W-1:0]  axis_first;
        logic [VEC_W-1:0]  axis_second;
        logic [VEC_W-1:0]  axis_third;
    } t_in_word;

    typedef struct packed {
        logic             hit;
        logic [VEC_W-1:0] closest_point;
    } t_out_word;

endpackage

### hw/rtl/soi_in_if.sv
// Channel interface carrying query words into the block.
interface soi_in_if;
    import soi_pkg::*;

    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/soi_out_if.sv
// Channel interface carrying result words out of the block.
interface soi_out_if;
    import soi_pkg::*;

    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/sphere_obb_intersect.sv
// Sphere versus oriented box test: closest box point and hit flag, nine-stage pipeline.
//
//   channel  | dir | handshake      | word
//   ---------+-----+----------------+------------------------------------------------
//   i_in     | in  | valid / ready  | sphere centre, radius, box centre, half sizes, axes
//   o_out    | out | valid / ready  | hit, closest point (saturated)
//
// One word per cycle sustained while o_out.ready is high; o_out.valid rises once the word reaches stage 8.
// Throughput is set by the nine-entry register pipeline, one word in each stage.
// Reset (i_rst_n low at a clock edge, synchronous) clears every stage valid bit only.
// Each stage moves on when it is empty or the stage after it moves, so a stall at
// o_out fills bubbles first and only then drops i_in.ready; nothing is lost or repeated.
module sphere_obb_intersect (
    input  logic       i_clk,
    input  logic       i_rst_n,
    soi_in_if.sink     i_in,
    soi_out_if.source  o_out
);
    import soi_pkg::*;

`include "sphere_obb_intersect_macros.svh"

    // ---------------------------------------------------------------------
    // Stage flow control
    // ---------------------------------------------------------------------
    logic [N_STAGES-1:0] r_v;
    logic [N_STAGES-1:0] n_v;
    logic [N_STAGES-1:0] stage_adv;

    always_comb begin
        stage_adv[N_STAGES-1] = !r_v[N_STAGES-1] || o_out.ready;
        for (int k = N_STAGES - 2; k >= 0; k--) begin
            stage_adv[k] = !r_v[k] || stage_adv[k+1];
        end
    end

    assign n_v        = {r_v[N_STAGES-2:0], i_in.valid};
    assign i_in.ready = stage_adv[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < N_STAGES; k++) begin
                if (stage_adv[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 0: unpack, centre offset d = sphere - box
    // ---------------------------------------------------------------------
    t_comp              u_sc [3];
    t_comp              u_bc [3];
    t_comp              u_ax [3][3];
    logic [COMP_W-1:0]  u_h  [3];

    t_comp              r_sc0 [3];
    t_comp              r_bc0 [3];
    t_comp              r_ax0 [3][3];
    logic [COMP_W-1:0]  r_h0  [3];
    logic [COMP_W-1:0]  r_r0;
    logic signed [D_W-1:0] r_d0 [3];

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            u_sc[j]    = $signed(i_in.data.sphere_center[j*COMP_W +: COMP_W]);
            u_bc[j]    = $signed(i_in.data.box_center[j*COMP_W +: COMP_W]);
            u_h[j]     = i_in.data.box_half_size[j*COMP_W +: COMP_W];
            u_ax[0][j] = $signed(i_in.data.axis_first[j*COMP_W +: COMP_W]);
            u_ax[1][j] = $signed(i_in.data.axis_second[j*COMP_W +: COMP_W]);
            u_ax[2][j] = $signed(i_in.data.axis_third[j*COMP_W +: COMP_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[0]) begin
            r_sc0 <= u_sc;
            r_bc0 <= u_bc;
            r_ax0 <= u_ax;
            r_h0  <= u_h;
            r_r0  <= i_in.data.sphere_radius;
            for (int j = 0; j < 3; j++) begin
                r_d0[j] <= D_W'(u_sc[j]) - D_W'(u_bc[j]);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stage 1: products d_j * a_ij, radius squared
    // ---------------------------------------------------------------------
    logic signed [P_W-1:0] r_p1 [3][3];
    logic [RR_W-1:0]       r_rr1;
    t_comp                 r_sc1 [3];
    t_comp                 r_bc1 [3];
    t_comp                 r_ax1 [3][3];
    logic [COMP_W-1:0]     r_h1  [3];

    always_ff @(posedge i_clk) begin
        if (stage_adv[1]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p1[i][j] <= P_W'(r_d0[j]) * P_W'(r_ax0[i][j]);
                end
            end
            r_rr1 <= RR_W'(r_r0) * RR_W'(r_r0);
            r_sc1 <= r_sc0;
            r_bc1 <= r_bc0;
            r_ax1 <= r_ax0;
            r_h1  <= r_h0;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 2: projection sums, rounding bias folded in
    // ---------------------------------------------------------------------
    logic signed [ACC1_W-1:0] r_acc2 [3];
    logic [RR_W-1:0]          r_rr2;
    t_comp                    r_sc2 [3];
    t_comp                    r_bc2 [3];
    t_comp                    r_ax2 [3][3];
    logic [COMP_W-1:0]        r_h2  [3];

    always_ff @(posedge i_clk) begin
        if (stage_adv[2]) begin
            for (int i = 0; i < 3; i++) begin
                r_acc2[i] <= ACC1_W'(r_p1[i][0]) + ACC1_W'(r_p1[i][1])
                           + ACC1_W'(r_p1[i][2]) + RND_BIAS;
            end
            r_rr2 <= r_rr1;
            r_sc2 <= r_sc1;
            r_bc2 <= r_bc1;
            r_ax2 <= r_ax1;
            r_h2  <= r_h1;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 3: drop fraction bits, clamp to +/- half size
    // ---------------------------------------------------------------------
    logic signed [D_W-1:0]    n_dist [3];
    logic signed [RND1_W-1:0] n_rnd  [3];
    logic signed [RND1_W-1:0] n_hh   [3];

    logic signed [D_W-1:0] r_dist3 [3];
    logic [COMP_W-1:0]     r_h3    [3];
    logic [RR_W-1:0]       r_rr3;
    t_comp                 r_sc3 [3];
    t_comp                 r_bc3 [3];
    t_comp                 r_ax3 [3][3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_rnd[i] = $signed(r_acc2[i][AXIS_FRAC +: RND1_W]);
            n_hh[i]  = $signed({{(RND1_W - COMP_W){1'b0}}, r_h2[i]});
            if (n_rnd[i] > n_hh[i]) begin
                n_dist[i] = D_W'(n_hh[i]);
            end else if (n_rnd[i] < -n_hh[i]) begin
                n_dist[i] = D_W'(-n_hh[i]);
            end else begin
                n_dist[i] = D_W'(n_rnd[i]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[3]) begin
            r_dist3 <= n_dist;
            r_h3    <= r_h2;
            r_rr3   <= r_rr2;
            r_sc3   <= r_sc2;
            r_bc3   <= r_bc2;
            r_ax3   <= r_ax2;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 4: products dist_i * a_ij; box centre at axis scale plus half LSB
    // ---------------------------------------------------------------------
    logic signed [P_W-1:0]    r_p4   [3][3];
    logic signed [ACC2_W-1:0] r_bcs4 [3];
    logic [RR_W-1:0]          r_rr4;
    t_comp                    r_sc4 [3];

    always_ff @(posedge i_clk) begin
        if (stage_adv[4]) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_p4[i][j] <= P_W'(r_dist3[i]) * P_W'(r_ax3[i][j]);
                end
            end
            for (int j = 0; j < 3; j++) begin
                r_bcs4[j] <= ACC2_W'($signed({r_bc3[j], 1'b1, {(AXIS_FRAC - 1){1'b0}}}));
            end
            r_rr4 <= r_rr3;
            r_sc4 <= r_sc3;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 5: rebuilt point sums per world axis
    // ---------------------------------------------------------------------
    logic signed [ACC2_W-1:0] r_acc5 [3];
    logic [RR_W-1:0]          r_rr5;
    t_comp                    r_sc5 [3];

    always_ff @(posedge i_clk) begin
        if (stage_adv[5]) begin
            for (int j = 0; j < 3; j++) begin
                r_acc5[j] <= r_bcs4[j] + ACC2_W'(r_p4[0][j]) + ACC2_W'(r_p4[1][j])
                           + ACC2_W'(r_p4[2][j]);
            end
            r_rr5 <= r_rr4;
            r_sc5 <= r_sc4;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 6: round, difference to sphere centre, saturate for output
    // ---------------------------------------------------------------------
    logic signed [CP_W-1:0] n_cp  [3];
    t_comp                  n_sat [3];

    logic signed [V_W-1:0] r_v6   [3];
    t_comp                 r_sat6 [3];
    logic [RR_W-1:0]       r_rr6;

    always_comb begin
        for (int j = 0; j < 3; j++) begin
            n_cp[j] = $signed(r_acc5[j][AXIS_FRAC +: CP_W]);
            if (n_cp[j] > SAT_MAX) begin
                n_sat[j] = COMP_W'(SAT_MAX);
            end else if (n_cp[j] < SAT_MIN) begin
                n_sat[j] = COMP_W'(SAT_MIN);
            end else begin
                n_sat[j] = COMP_W'(n_cp[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_adv[6]) begin
            for (int j = 0; j < 3; j++) begin
                r_v6[j] <= V_W'(n_cp[j]) - V_W'(r_sc5[j]);
            end
            r_sat6 <= n_sat;
            r_rr6  <= r_rr5;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 7: squares
    // ---------------------------------------------------------------------
    logic [SQ_W-1:0] r_sq7 [3];
    t_comp           r_sat7 [3];
    logic [RR_W-1:0] r_rr7;

    always_ff @(posedge i_clk) begin
        if (stage_adv[7]) begin
            for (int j = 0; j < 3; j++) begin
                r_sq7[j] <= SQ_W'(r_v6[j]) * SQ_W'(r_v6[j]);
            end
            r_sat7 <= r_sat6;
            r_rr7  <= r_rr6;
        end
    end

    // ---------------------------------------------------------------------
    // Stage 8: squared distance against radius squared; output register
    // ---------------------------------------------------------------------
    logic [DD_W-1:0]  n_dd;
    logic             r_hit8;
    logic [VEC_W-1:0] r_cp8;

    assign n_dd = DD_W'(r_sq7[0]) + DD_W'(r_sq7[1]) + DD_W'(r_sq7[2]);

    always_ff @(posedge i_clk) begin
        if (stage_adv[8]) begin
            r_hit8 <= (n_dd <= DD_W'(r_rr7));
            for (int j = 0; j < 3; j++) begin
                r_cp8[j*COMP_W +: COMP_W] <= r_sat7[j];
            end
        end
    end

    assign o_out.valid              = r_v[N_STAGES-1];
    assign o_out.data.hit           = r_hit8;
    assign o_out.data.closest_point = r_cp8;

    // ---------------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------------
    `SOI_ASSERT_NEXT(a_enter, i_in.valid && i_in.ready, r_v[0], "accepted word missing from stage 0")
    `SOI_ASSERT_NEXT(a_hold, r_v[3] && !stage_adv[3], r_v[3] && $stable(r_dist3[0]), "stalled stage 3 lost its word")
    `SOI_ASSERT_IMPL(a_clamp, r_v[3], (r_dist3[0] <= $signed({1'b0, r_h3[0]})) && (r_dist3[0] >= -$signed({1'b0, r_h3[0]})) && (r_dist3[2] <= $signed({1'b0, r_h3[2]})) && (r_dist3[2] >= -$signed({1'b0, r_h3[2]})), "projection outside half size")
    `SOI_ASSERT_IMPL(a_ready, !r_v[0], i_in.ready, "empty entry stage refused a word")

endmodule
